### sv/apcs_pkg.sv
// Shared constants and types for the prologue and call scanner.
package apcs_pkg;

  localparam int OFFSET_BITS = 32;
  localparam int OFF_W = (OFFSET_BITS >= 32) ? 32 : OFFSET_BITS;
  localparam logic [OFF_W-1:0] OFF_MAX = {OFF_W{1'b1}};
  localparam logic [OFF_W-1:0] OFF_STEP = OFF_W'(4);
  localparam logic [OFF_W-1:0] OFF_SAT_AT = OFF_MAX - OFF_STEP;

  localparam int CFG_IDX_W = 8;
  localparam logic [CFG_IDX_W-1:0] CFG_BASE_ADDRESS = CFG_IDX_W'(0);
  localparam logic [CFG_IDX_W-1:0] CFG_CODE_SIZE    = CFG_IDX_W'(1);

  localparam logic [31:0] PRE_STP_MASK = 32'hFFC0_03FF;
  localparam logic [31:0] PRE_STP_VAL  = 32'hA980_03FF;
  localparam logic [31:0] SUB_SP_MASK  = 32'hFF00_03FF;
  localparam logic [31:0] SUB_SP_VAL   = 32'hD100_03FF;
  localparam logic [31:0] OFF_STP_MASK = 32'hFFC0_0000;
  localparam logic [31:0] OFF_STP_VAL  = 32'hA900_0000;
  localparam logic [31:0] BL_MASK      = 32'hFC00_0000;
  localparam logic [31:0] BL_VAL       = 32'h9400_0000;
  localparam logic [31:0] IMM26_MASK   = 32'h03FF_FFFF;
  localparam logic [31:0] IMM26_SIGN   = 32'h0200_0000;

  typedef struct packed {
    logic [OFF_W-1:0] byte_offset;
    logic             pending_sub;
    logic [OFF_W-1:0] sub_offset;
  } scan_state_t;

  typedef struct packed {
    logic        prologue_found;
    logic [31:0] prologue_offset;
    logic        call_found;
    logic [63:0] call_target;
    logic        sub_hit;
  } decode_res_t;

endpackage

### sv/arm64_prologue_and_call_scanner_unit.sv
// Top level: input register, word decode, scan state and result register.
// A transferred word is captured in the input register, then its decode result is registered in the result register.
// Throughput: one word per cycle while out_stall is low; the input and result
// registers advance together, so a full pipeline sustains a transfer every cycle.
// Reset (rst_n low, synchronous) clears both registers' valid flags, the
// scan offset and pending subtract, and sets base_address and code_size to 0.
module arm64_prologue_and_call_scanner_unit import apcs_pkg::*; (
  input  logic                 clk,
  input  logic                 rst_n,
  input  logic                 in_valid,
  output logic                 in_stall,
  input  logic [31:0]          in_insn_word,
  input  logic                 in_last_word,
  output logic                 out_valid,
  input  logic                 out_stall,
  output logic                 out_prologue_found,
  output logic [31:0]          out_prologue_offset,
  output logic                 out_call_found,
  output logic [63:0]          out_call_target,
  output logic                 out_end_of_scan,
  input  logic                 cfg_wr_en,
  input  logic [CFG_IDX_W-1:0] cfg_index,
  input  logic [63:0]          cfg_wdata
);

  logic        in_valid_r;
  logic [31:0] word_r;
  logic        last_r;
  logic        out_valid_r;
  logic [63:0] base_r;
  logic [31:0] size_r;
  scan_state_t st_r;
  scan_state_t st_nxt;
  decode_res_t dec;
  decode_res_t res_r;
  logic        eos_r;
  logic        out_adv;
  logic        in_adv;
  logic        fire;

  assign out_adv  = !out_valid_r || !out_stall;
  assign fire     = in_valid_r && out_adv;
  assign in_adv   = !in_valid_r || out_adv;
  assign in_stall = !in_adv;

  apcs_decode u_decode (
    .insn_word    (word_r),
    .last_word    (last_r),
    .st           (st_r),
    .base_address (base_r),
    .code_size    (size_r),
    .res          (dec)
  );

  always_comb begin
    st_nxt = st_r;
    st_nxt.pending_sub = dec.sub_hit;
    if (dec.sub_hit) begin
      st_nxt.sub_offset = st_r.byte_offset;
    end
    if (last_r) begin
      st_nxt = '0;
    end else if (st_r.byte_offset > OFF_SAT_AT) begin
      st_nxt.byte_offset = OFF_MAX;
    end else begin
      st_nxt.byte_offset = st_r.byte_offset + OFF_STEP;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r  <= 1'b0;
      out_valid_r <= 1'b0;
      st_r        <= '0;
      base_r      <= '0;
      size_r      <= '0;
    end else begin
      if (in_adv) begin
        in_valid_r <= in_valid;
      end
      if (out_adv) begin
        out_valid_r <= in_valid_r;
      end
      if (fire) begin
        st_r <= st_nxt;
      end
      if (cfg_wr_en) begin
        unique case (cfg_index)
          CFG_BASE_ADDRESS: base_r <= cfg_wdata;
          CFG_CODE_SIZE:    size_r <= cfg_wdata[31:0];
          default: ;
        endcase
      end
    end
  end

  always_ff @(posedge clk) begin
    if (in_adv) begin
      word_r <= in_insn_word;
      last_r <= in_last_word;
    end
    if (fire) begin
      res_r <= dec;
      eos_r <= last_r;
    end
  end

  assign out_valid           = out_valid_r;
  assign out_prologue_found  = res_r.prologue_found;
  assign out_prologue_offset = res_r.prologue_offset;
  assign out_call_found      = res_r.call_found;
  assign out_call_target     = res_r.call_target;
  assign out_end_of_scan     = eos_r;

endmodule

### sv/apcs_decode.sv
// Instruction word decode: prologue patterns and BL target bound check.
module apcs_decode import apcs_pkg::*; (
  input  logic [31:0]  insn_word,
  input  logic         last_word,
  input  scan_state_t  st,
  input  logic [63:0]  base_address,
  input  logic [31:0]  code_size,
  output decode_res_t  res
);

  logic        is_pre_stp;
  logic        is_off_stp;
  logic        is_sub_sp;
  logic        is_bl;
  logic [63:0] imm_ext;
  logic [63:0] diff;
  logic [63:0] target;
  logic        in_region;

  assign is_pre_stp = (insn_word & PRE_STP_MASK) == PRE_STP_VAL;
  assign is_off_stp = (insn_word & OFF_STP_MASK) == OFF_STP_VAL;
  assign is_sub_sp  = (insn_word & SUB_SP_MASK) == SUB_SP_VAL;
  assign is_bl      = (insn_word & BL_MASK) == BL_VAL;

  assign imm_ext = {{36{insn_word[25]}}, insn_word[25:0], 2'b00};
  assign diff    = 64'(st.byte_offset) + imm_ext;
  assign target  = base_address + diff;
  assign in_region = (target != 64'd0) && (target >= base_address) &&
                     (diff < {32'd0, code_size});

  always_comb begin
    res = '0;
    priority if (st.pending_sub && is_off_stp) begin
      res.prologue_found  = 1'b1;
      res.prologue_offset = 32'(st.sub_offset);
    end else if (is_pre_stp) begin
      res.prologue_found  = 1'b1;
      res.prologue_offset = 32'(st.byte_offset);
    end else begin
      res.prologue_found  = 1'b0;
    end
    if (is_bl && in_region) begin
      res.call_found  = 1'b1;
      res.call_target = target;
    end
    res.sub_hit = is_sub_sp && !last_word;
  end

endmodule

### sv/apcs_checker.sv
// Port-level checker for the scanner, bound to the top level.
module apcs_checker import apcs_pkg::*; (
  input logic        clk,
  input logic        rst_n,
  input logic        out_valid,
  input logic        out_stall,
  input logic        out_prologue_found,
  input logic [31:0] out_prologue_offset,
  input logic        out_call_found,
  input logic [63:0] out_call_target
);

  a_out_hold: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_stall |=> out_valid)
    else $error("result dropped while stalled");

  a_call_nonzero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && out_call_found |-> out_call_target != 64'd0)
    else $error("call reported with zero target");

  a_no_call_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_call_found |-> out_call_target == 64'd0)
    else $error("call target set without call");

  a_no_pro_zero: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid && !out_prologue_found |-> out_prologue_offset == 32'd0)
    else $error("prologue offset set without prologue");

endmodule

bind arm64_prologue_and_call_scanner_unit apcs_checker u_apcs_checker (
  .clk                 (clk),
  .rst_n               (rst_n),
  .out_valid           (out_valid),
  .out_stall           (out_stall),
  .out_prologue_found  (out_prologue_found),
  .out_prologue_offset (out_prologue_offset),
  .out_call_found      (out_call_found),
  .out_call_target     (out_call_target)
);
